[src/sbm_pkg.sv]
// Shared constants and register codes for the stereo block-matching disparity block.
package sbm_pkg;

  localparam int unsigned WindowRadiusDef = 5;
  localparam int unsigned MaxDisparityDef = 15;
  localparam int unsigned MaxLineWidthDef = 1024;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COST_W    = 17;
  localparam int unsigned ROOT_W    = 13;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned DISP_W    = 4;

  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned SIZE_REG_W  = 11;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [1:0] REG_COST_MODE    = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;

endpackage

[src/sbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/sbm_isqrt.sv]
// Iterative square root, one result bit per cycle, of a squared distance in fixed point.
module sbm_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sbm_pkg::COST_W-1:0] radicand_i,
  output logic                       done_o,
  output logic [sbm_pkg::ROOT_W-1:0] root_o
);
  import sbm_pkg::*;

  localparam int unsigned V_W   = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 4;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [V_W-1:0]    v_q;
  logic [REM_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [REM_W-1:0]  rem_d;
  logic [REM_W-1:0]  trial;

  assign rem_d = {rem_q[REM_W-3:0], v_q[V_W-1 -: 2]};
  assign trial = REM_W'({root_o, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_o <= 1'b0;
      root_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        // radicand scaled by 2^(2*FRAC_BITS) gives FRAC_BITS fraction bits of root
        v_q    <= V_W'({radicand_i, (2 * FRAC_BITS)'(0)});
        rem_q  <= '0;
        root_o <= '0;
        cnt_q  <= CNT_W'(ROOT_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        v_q <= {v_q[V_W-3:0], 2'b00};
        if (rem_d >= trial) begin
          rem_q  <= rem_d - trial;
          root_o <= {root_o[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_d;
          root_o <= {root_o[ROOT_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

[src/stereo_block_match_disparity.sv]
// Every pixel request yields exactly one result request, in order. A pixel that completes no
// centre is accepted, then its result is emitted. A pixel that completes n centres first
// computes MAX_DISPARITY+1 window sums per centre, each over S*S pixel pairs with
// S = 2*WINDOW_RADIUS+1; the window sum walks both line-store RAMs
// one pixel pair per read, and in distance mode each pair waits for the bit-serial root
// unit. n is 1 mid-row and up to MAX_DISPARITY+1 on the last pixel of a row. Line stores
// hold 2*WINDOW_RADIUS+1 rows and need no clearing; results queue MAX_DISPARITY+1 deep.
module stereo_block_match_disparity #(
  parameter int unsigned WINDOW_RADIUS  = sbm_pkg::WindowRadiusDef,
  parameter int unsigned MAX_DISPARITY  = sbm_pkg::MaxDisparityDef,
  parameter int unsigned MAX_LINE_WIDTH = sbm_pkg::MaxLineWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: right_a[7:0], right_b[15:8], left_a[23:16], left_b[31:24]
  input  logic [sbm_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: start_of_frame
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: disparity[3:0], zero [7:4]
  output logic [sbm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: result_valid
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbm_pkg::PADDR_W-1:0]      paddr,
  input  logic [sbm_pkg::PDATA_W-1:0]      pwdata,
  output logic [sbm_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import sbm_pkg::*;

  localparam int unsigned S       = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned SW      = $clog2(S);
  localparam int unsigned COL_W   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned DEPTH   = S * MAX_LINE_WIDTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned D_W     = $clog2(MAX_DISPARITY + 1);
  localparam int unsigned QDEPTH  = MAX_DISPARITY + 1;
  localparam int unsigned QI_W    = $clog2(QDEPTH);
  localparam int unsigned QC_W    = $clog2(QDEPTH + 1);
  localparam int unsigned SUM_W   = COST_W + $clog2(S * S);
  localparam int unsigned PIXP_W  = 2 * PIX_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_COST, ST_SQRT, ST_ACC, ST_CMP, ST_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic                  cost_mode_q;
  logic [SIZE_REG_W-1:0] line_width_q;
  logic [SIZE_REG_W-1:0] frame_height_q;
  logic                  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_mode_q    <= 1'b0;
      line_width_q   <= SIZE_RESET;
      frame_height_q <= SIZE_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_COST_MODE:    cost_mode_q    <= pwdata[0];
        REG_LINE_WIDTH:   line_width_q   <= pwdata[SIZE_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COST_MODE:    prdata = PDATA_W'(cost_mode_q);
      REG_LINE_WIDTH:   prdata = PDATA_W'(line_width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  logic [COL_W-1:0]      w_eff;
  logic [SIZE_REG_W-1:0] h_eff;

  always_comb begin
    if (line_width_q == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(line_width_q) > MAX_LINE_WIDTH) begin
      w_eff = COL_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = COL_W'(line_width_q);
    end
    h_eff = (frame_height_q == '0) ? SIZE_REG_W'(1) : frame_height_q;
  end

  // position
  logic [COL_W-1:0]      col_q, col_a, col_n;
  logic [SIZE_REG_W-1:0] row_q, row_a, row_n;
  logic [SW-1:0]         slot_q, slot_a, slot_n, slot0;
  logic                  accept;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    col_a  = col_q;
    row_a  = row_q;
    slot_a = slot_q;
    if (s_axis_tuser_i) begin
      col_a  = '0;
      row_a  = '0;
      slot_a = '0;
    end
    if (col_a >= w_eff) begin
      col_a  = '0;
      row_a  = row_a + 1'b1;
      slot_a = (slot_a == SW'(S - 1)) ? '0 : slot_a + 1'b1;
    end
    if (row_a >= h_eff) begin
      row_a  = '0;
      slot_a = '0;
    end
    col_n  = col_a + 1'b1;
    row_n  = row_a;
    slot_n = slot_a;
    if (col_n >= w_eff) begin
      col_n = '0;
      if (row_a + 1'b1 >= h_eff) begin
        row_n  = '0;
        slot_n = '0;
      end else begin
        row_n  = row_a + 1'b1;
        slot_n = (slot_a == SW'(S - 1)) ? '0 : slot_a + 1'b1;
      end
    end
    // oldest stored row of the window follows the newest one in the ring
    slot0 = (slot_a == SW'(S - 1)) ? '0 : slot_a + 1'b1;
  end

  // which centres this pixel completes
  logic             row_ok, a_hit, b_hit, go, last_en;
  logic [31:0]      w32, xs32;
  logic [COL_W-1:0] x_lo, x_hi, x_a;

  always_comb begin
    w32    = 32'(w_eff);
    row_ok = 32'(row_a) >= 2 * WINDOW_RADIUS;
    a_hit  = 32'(col_a) >= 2 * WINDOW_RADIUS + MAX_DISPARITY;
    b_hit  = (32'(col_a) == w32 - 1) && (w32 > 2 * WINDOW_RADIUS);
    x_a    = COL_W'(32'(col_a) - WINDOW_RADIUS - MAX_DISPARITY);
    xs32   = WINDOW_RADIUS;
    if (w32 > WINDOW_RADIUS + MAX_DISPARITY &&
        w32 - WINDOW_RADIUS - MAX_DISPARITY > WINDOW_RADIUS) begin
      xs32 = w32 - WINDOW_RADIUS - MAX_DISPARITY;
    end
    x_lo    = a_hit ? x_a : COL_W'(xs32);
    x_hi    = b_hit ? COL_W'(w32 - 1 - WINDOW_RADIUS) : x_a;
    last_en = b_hit && (row_a == h_eff - 1'b1);
    go      = row_ok && (a_hit || b_hit);
  end

  // window walk
  logic [COL_W-1:0]  x_q, xhi_q;
  logic              last_en_q;
  logic [D_W-1:0]    d_q, best_q, best_nx;
  logic [SW-1:0]     i_q, j_q, slot0_q, slotj_q;
  logic [SUM_W-1:0]  sum_q, bestc_q;
  logic              oobr_q, oobl_q;
  logic [COST_W-1:0] q_q, q_val, cost;
  logic [31:0]       rc32, lc32;
  logic              r_oob, l_oob, better;
  logic [COL_W-1:0]  rcol, lcol;
  logic [ADDR_W-1:0] waddr, raddr_r, raddr_l;
  logic [PIXP_W-1:0] rdata_r, rdata_l, rpix, lpix;
  logic [PIX_W-1:0]  da, db;

  always_comb begin
    rc32  = 32'(x_q) + 32'(i_q) - WINDOW_RADIUS;
    lc32  = rc32 + 32'(d_q);
    r_oob = rc32 >= 32'(w_eff);
    l_oob = lc32 >= 32'(w_eff);
    rcol  = r_oob ? '0 : COL_W'(rc32);
    lcol  = l_oob ? '0 : COL_W'(lc32);
  end

  assign waddr   = ADDR_W'(32'(slot_a) * MAX_LINE_WIDTH + 32'(col_a));
  assign raddr_r = ADDR_W'(32'(slotj_q) * MAX_LINE_WIDTH + 32'(rcol));
  assign raddr_l = ADDR_W'(32'(slotj_q) * MAX_LINE_WIDTH + 32'(lcol));

  sbm_ram #(.WIDTH(PIXP_W), .DEPTH(DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i ({s_axis_tdata_i[7:0], s_axis_tdata_i[15:8]}),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  sbm_ram #(.WIDTH(PIXP_W), .DEPTH(DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i ({s_axis_tdata_i[23:16], s_axis_tdata_i[31:24]}),
    .raddr_i (raddr_l),
    .rdata_o (rdata_l)
  );

  // pixel cost; pixel word is {a, b}
  always_comb begin
    rpix  = oobr_q ? '0 : rdata_r;
    lpix  = oobl_q ? '0 : rdata_l;
    da    = (rpix[15:8] >= lpix[15:8]) ? rpix[15:8] - lpix[15:8] : lpix[15:8] - rpix[15:8];
    db    = (rpix[7:0] >= lpix[7:0]) ? rpix[7:0] - lpix[7:0] : lpix[7:0] - rpix[7:0];
    q_val = COST_W'(da * da) + COST_W'(db * db);
  end

  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  assign sq_start = (state_q == ST_COST) && cost_mode_q;

  sbm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (q_val),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign cost    = cost_mode_q ? COST_W'(sq_root) : q_q;
  assign better  = (d_q == '0) || (sum_q < bestc_q);
  assign best_nx = better ? d_q : best_q;

  // result queue
  logic [DISP_W-1:0] qd_q [QDEPTH];
  logic              ql_q [QDEPTH];
  logic [QI_W-1:0]   qhead_q, qtail;
  logic [QC_W-1:0]   qcnt_q;
  logic              push;
  logic [31:0]       tail32;

  always_comb begin
    tail32 = 32'(qhead_q) + 32'(qcnt_q);
    if (tail32 >= QDEPTH) begin
      tail32 = tail32 - QDEPTH;
    end
    qtail = QI_W'(tail32);
  end

  assign push = (state_q == ST_CMP) && (d_q == D_W'(MAX_DISPARITY)) &&
                (32'(qcnt_q) < QDEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      qd_q[qtail] <= DISP_W'(best_nx);
      ql_q[qtail] <= last_en_q && (x_q == xhi_q);
    end
  end

  logic                  m_valid_q, m_user_q, m_last_q;
  logic [DISP_W-1:0]     m_disp_q;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(m_disp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      x_q       <= '0;
      xhi_q     <= '0;
      last_en_q <= 1'b0;
      d_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      slot0_q   <= '0;
      slotj_q   <= '0;
      sum_q     <= '0;
      best_q    <= '0;
      bestc_q   <= '0;
      oobr_q    <= 1'b0;
      oobl_q    <= 1'b0;
      q_q       <= '0;
      qhead_q   <= '0;
      qcnt_q    <= '0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
      m_last_q  <= 1'b0;
      m_disp_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            col_q     <= col_n;
            row_q     <= row_n;
            slot_q    <= slot_n;
            x_q       <= x_lo;
            xhi_q     <= x_hi;
            last_en_q <= last_en;
            slot0_q   <= slot0;
            slotj_q   <= slot0;
            i_q       <= '0;
            j_q       <= '0;
            d_q       <= '0;
            sum_q     <= '0;
            state_q   <= go ? ST_READ : ST_EMIT;
          end
        end
        ST_READ: begin
          oobr_q  <= r_oob;
          oobl_q  <= l_oob;
          state_q <= ST_COST;
        end
        ST_COST: begin
          q_q     <= q_val;
          state_q <= cost_mode_q ? ST_SQRT : ST_ACC;
        end
        ST_SQRT: begin
          if (sq_done) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_q   <= sum_q + SUM_W'(cost);
          state_q <= ST_READ;
          if (i_q == SW'(S - 1)) begin
            i_q <= '0;
            if (j_q == SW'(S - 1)) begin
              j_q     <= '0;
              state_q <= ST_CMP;
            end else begin
              j_q     <= j_q + 1'b1;
              slotj_q <= (slotj_q == SW'(S - 1)) ? '0 : slotj_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_CMP: begin
          if (better) begin
            best_q  <= d_q;
            bestc_q <= sum_q;
          end
          sum_q   <= '0;
          slotj_q <= slot0_q;
          state_q <= ST_READ;
          if (d_q == D_W'(MAX_DISPARITY)) begin
            if (push) begin
              qcnt_q <= qcnt_q + 1'b1;
            end
            d_q <= '0;
            if (x_q == xhi_q) begin
              state_q <= ST_EMIT;
            end else begin
              x_q <= x_q + 1'b1;
            end
          end else begin
            d_q <= d_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
            if (qcnt_q != '0) begin
              m_user_q <= 1'b1;
              m_disp_q <= qd_q[qhead_q];
              m_last_q <= ql_q[qhead_q];
              qhead_q  <= (qhead_q == QI_W'(QDEPTH - 1)) ? '0 : qhead_q + 1'b1;
              qcnt_q   <= qcnt_q - 1'b1;
            end else begin
              m_user_q <= 1'b0;
              m_disp_q <= '0;
              m_last_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qcnt_q) <= QDEPTH)
    else $error("result queue overfilled");

  a_last_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_last_q |-> m_user_q)
    else $error("frame end flagged on an empty result");

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) <= MAX_LINE_WIDTH)
    else $error("column position beyond line store");

  a_accept_no_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ || state_q == ST_EMIT))
    else $error("pixel accepted without starting work");
`endif

endmodule

[sim/sbm_checker.sv]
// Stream watcher that predicts disparity results for stereo_block_match_disparity and checks them.
`timescale 1ns / 100ps

module sbm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sbm_pkg::IN_TDATA_W-1:0]  pix_tdata_i,
  input  logic                            pix_tuser_i,
  input  logic                            pix_tvalid_i,
  input  logic                            pix_tready_i,
  input  logic [sbm_pkg::OUT_TDATA_W-1:0] res_tdata_i,
  input  logic                            res_tuser_i,
  input  logic                            res_tlast_i,
  input  logic                            res_tvalid_i,
  input  logic                            res_tready_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [sbm_pkg::PADDR_W-1:0]     paddr_i,
  input  logic [sbm_pkg::PDATA_W-1:0]     pwdata_i,
  output int                              err_cnt_o,
  output int                              pending_o
);
  import sbm_pkg::*;

  localparam int Rad   = WindowRadiusDef;
  localparam int MaxD  = MaxDisparityDef;
  localparam int MaxW  = MaxLineWidthDef;
  localparam int Rows  = 2 * Rad + 1;

  typedef struct packed {
    logic             valid;
    logic [DISP_W-1:0] disp;
    logic             last;
  } disp_res_t;

  logic [15:0] right_rows [Rows][MaxW];
  logic [15:0] left_rows  [Rows][MaxW];
  logic                  sq_root_mode;
  logic [SIZE_REG_W-1:0] line_w;
  logic [SIZE_REG_W-1:0] frame_h;
  int unsigned           col_pos;
  int unsigned           row_pos;
  disp_res_t             centre_q[$];
  disp_res_t             disp_expected[$];

  assign pending_o = disp_expected.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned match_cost(logic [15:0] rp, logic [15:0] lp);
    longint signed da;
    longint signed db;
    longint unsigned q;
    da = longint'(rp[15:8]) - longint'(lp[15:8]);
    db = longint'(rp[7:0]) - longint'(lp[7:0]);
    q = longint'(da * da + db * db);
    return sq_root_mode ? int_sqrt(q << 8) : q;
  endfunction

  function automatic logic [DISP_W-1:0] pick_disparity(int unsigned x, int unsigned y,
                                                      int unsigned w);
    longint unsigned sum;
    longint unsigned best_sum;
    int unsigned     best;
    int unsigned     base;
    int unsigned     rc;
    logic [15:0]     rp;
    logic [15:0]     lp;
    best = 0;
    best_sum = 0;
    for (int d = 0; d <= MaxD; d++) begin
      sum = 0;
      for (int j = 0; j < Rows; j++) begin
        base = (y - Rad + j) % Rows;
        for (int i = 0; i < Rows; i++) begin
          rc = x - Rad + i;
          rp = (rc < w) ? right_rows[base][rc] : 16'd0;
          lp = (rc + d < w) ? left_rows[base][rc + d] : 16'd0;
          sum += match_cost(rp, lp);
        end
      end
      if (d == 0 || sum < best_sum) begin
        best_sum = sum;
        best = d;
      end
    end
    return best[DISP_W-1:0];
  endfunction

  function automatic void queue_centre(logic [DISP_W-1:0] d, logic last);
    if (centre_q.size() < MaxD + 1) centre_q.push_back('{1'b1, d, last});
  endfunction

  // one pixel request in, one expected result out
  function automatic void take_pixel(logic sof, logic [IN_TDATA_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned y;
    int unsigned x;
    int unsigned last_x;
    w = (line_w == 0) ? 1 : ((line_w > MaxW) ? MaxW : line_w);
    h = (frame_h == 0) ? 1 : frame_h;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    right_rows[r % Rows][c] = {px[7:0], px[15:8]};
    left_rows[r % Rows][c]  = {px[23:16], px[31:24]};
    if (r >= 2 * Rad) begin
      y = r - Rad;
      if (c >= 2 * Rad + MaxD) queue_centre(pick_disparity(c - Rad - MaxD, y, w), 1'b0);
      if (c == w - 1 && w > 2 * Rad) begin
        last_x = w - 1 - Rad;
        x = Rad;
        if (w > Rad + MaxD && w - Rad - MaxD > x) x = w - Rad - MaxD;
        for (; x <= last_x; x++)
          queue_centre(pick_disparity(x, y, w), (x == last_x) && (r == h - 1));
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    if (centre_q.size() > 0) disp_expected.push_back(centre_q.pop_front());
    else disp_expected.push_back('0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    disp_res_t exp_r;
    if (!rst_ni) begin
      sq_root_mode = 1'b0;
      line_w       = SIZE_RESET;
      frame_h      = SIZE_RESET;
      col_pos      = 0;
      row_pos      = 0;
      centre_q.delete();
      disp_expected.delete();
      err_cnt_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_COST_MODE:    sq_root_mode = pwdata_i[0];
          REG_LINE_WIDTH:   line_w = pwdata_i[SIZE_REG_W-1:0];
          REG_FRAME_HEIGHT: frame_h = pwdata_i[SIZE_REG_W-1:0];
          default: ;
        endcase
      end
      if (res_tvalid_i && res_tready_i) begin
        if (disp_expected.size() == 0) begin
          $error("unexpected result request: tdata=%0h", res_tdata_i);
          err_cnt_o++;
        end else begin
          exp_r = disp_expected.pop_front();
          if (res_tuser_i !== exp_r.valid) begin
            $error("result_valid: expected %0d, actual %0d", exp_r.valid, res_tuser_i);
            err_cnt_o++;
          end
          if (res_tdata_i !== {4'd0, exp_r.disp}) begin
            $error("disparity: expected %0d, actual %0d", exp_r.disp, res_tdata_i);
            err_cnt_o++;
          end
          if (res_tlast_i !== exp_r.last) begin
            $error("last_of_frame: expected %0d, actual %0d", exp_r.last, res_tlast_i);
            err_cnt_o++;
          end
        end
      end
      if (pix_tvalid_i && pix_tready_i) take_pixel(pix_tuser_i, pix_tdata_i);
    end
  end

endmodule

[sim/tb.sv]
// Top of the stereo_block_match_disparity testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import sbm_pkg::*;

  localparam int CycleLimit = 4000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  int                     err_cnt;
  int                     pending;
  int                     cycles = 0;
  int                     src_idle = 29;
  int                     snk_idle = 67;
  int                     sent = 0;
  logic [15:0]            right_line [1024];

  always #5 clk_i = ~clk_i;

  stereo_block_match_disparity u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser), .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sbm_checker u_chk (
    .clk_i, .rst_ni,
    .pix_tdata_i(s_tdata), .pix_tuser_i(s_tuser), .pix_tvalid_i(s_tvalid),
    .pix_tready_i(s_tready),
    .res_tdata_i(m_tdata), .res_tuser_i(m_tuser), .res_tlast_i(m_tlast),
    .res_tvalid_i(m_tvalid), .res_tready_i(m_tready),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= snk_idle);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL stereo_block_match_disparity");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(logic sof, logic [7:0] ra, logic [7:0] rb,
                            logic [7:0] la, logic [7:0] lb);
    logic rdy;
    // idle pattern shifts by thirds of the stimulus
    if (sent == 206) begin
      src_idle = 67;
      snk_idle = 29;
    end else if (sent == 412) begin
      src_idle = 0;
      snk_idle = 0;
    end
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= sof;
    s_tdata  <= {lb, la, rb, ra};
    do begin
      @(negedge clk_i);
      rdy = s_tready;
      @(posedge clk_i);
    end while (!rdy);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // right image random, left image the right one shifted by a drifting disparity
  task automatic send_frame(int w, int h, logic with_sof);
    int          shift;
    logic [15:0] rp;
    logic [15:0] lp;
    for (int r = 0; r < h; r++) begin
      shift = $urandom_range(0, 15);
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 19) == 0) shift = $urandom_range(0, 15);
        rp = 16'($urandom);
        if ($urandom_range(0, 9) == 0) rp = {$urandom_range(0, 1) ? 8'hff : 8'h00, rp[7:0]};
        right_line[c] = rp;
        lp = (c >= shift && $urandom_range(0, 7) != 0) ? right_line[c - shift] : 16'($urandom);
        send_pixel(with_sof && r == 0 && c == 0, rp[15:8], rp[7:0], lp[15:8], lp[7:0]);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // widest settings: first rows only, so no centre is computed
    reg_write(REG_COST_MODE, 32'd0);
    reg_write(REG_LINE_WIDTH, 32'd1024);
    reg_write(REG_FRAME_HEIGHT, 32'd1024);
    for (int k = 0; k < 24; k++) begin
      case (k % 4)
        0: send_pixel(k == 0 || k == 12, 8'h00, 8'h00, 8'h00, 8'h00);
        1: send_pixel(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
        2: send_pixel(1'b0, 8'hff, 8'h00, 8'h00, 8'hff);
        default: send_pixel(1'b0, 8'h00, 8'hff, 8'hff, 8'h00);
      endcase
    end
    drain();

    // smallest frame, squared distance
    reg_write(REG_LINE_WIDTH, 32'd27);
    reg_write(REG_FRAME_HEIGHT, 32'd11);
    send_frame(27, 11, 1'b1);
    drain();

    // distance mode; frame follows by wrap-around without start_of_frame
    reg_write(REG_COST_MODE, 32'd1);
    send_frame(27, 11, 1'b0);
    drain();

    if (err_cnt == 0) begin
      $display("PASS stereo_block_match_disparity");
    end else begin
      $display("FAIL stereo_block_match_disparity");
    end
    $finish;
  end

endmodule

[files.f]
src/sbm_pkg.sv
src/sbm_ram.sv
src/sbm_isqrt.sv
src/stereo_block_match_disparity.sv
sim/sbm_checker.sv
sim/tb.sv
